FILE: rtl/iaids_pkg.sv
// Package for the indexed array block: sizes, codes, request and response types.
// No dependencies; imported by every module of the block but iaids_ram.
`default_nettype none

package iaids_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int ACT_W    = 2;
	localparam int POS_W    = 7;
	localparam int FPOS_W   = 6;
	localparam int STAT_W   = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_VIEW   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_BOUNDS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_V_RD,
		S_V_OUT,
		S_I_CHK,
		S_I_WR,
		S_D_CHK,
		S_D_WR,
		S_S_CHK,
		S_S_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [FPOS_W-1:0]        found_position;
		logic signed [DATA_W-1:0] entry_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     last_of_run;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/indexed_array_insert_delete_search.sv
// Top level of the indexed array block: sequencer, store and output register.
// Depends on iaids_pkg, iaids_ram and iaids_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   request | in        | req_valid / req_stall| req  (action, position, value)
//   response| out       | rsp_valid / rsp_stall| rsp  (status, index, value, count, last)
//
// Walks: insert moves each entry from the position up one place, delete moves each entry
// after the position down one place, search compares entries until one matches, view reads
// every entry; a refused insert or delete walks nothing. Insert, delete, search and an
// empty view then hand the response over from a response state, and the sequencer
// returns to idle to take the next request. The store has one write port and one registered
// read port: every moved or compared entry costs a read step and a use step.
// Reset clears the count, the state and the output valid; the store is left as it is, no clearing pass.
// A stalled response holds; during a view the walk waits on the output register.
// No new request is taken until the previous one has handed over its last response.
`default_nettype none

module indexed_array_insert_delete_search import iaids_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic              idle;
	logic              req_take;
	logic              res_valid;
	logic              res_take;
	rsp_t              res;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// a request enters only when the sequencer is idle
	assign req_stall = !idle;
	assign req_take  = req_valid && idle;

	// output register frees as soon as its content is taken
	assign res_take  = res_valid && (!rsp_valid_q || !rsp_stall);

	iaids_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_take  (req_take),
		.req_in    (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	iaids_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/iaids_ram.sv
// Generic one-write, one-read memory with registered read data.
// No package dependency.
`default_nettype none

module iaids_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/iaids_seq.sv
// Sequencer for the indexed array: walks the store with one shared pointer
// step and one shared pointer compare. Depends on iaids_pkg.
`default_nettype none

module iaids_seq import iaids_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_take,
	input  wire req_t              req_in,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_take,
	output rsp_t                   res,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output logic [DATA_W-1:0]      ram_wdata,
	output logic                   ram_re,
	output logic [ADDR_W-1:0]      ram_raddr,
	input  wire logic [DATA_W-1:0] ram_rdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	status_t           rstat_q;
	logic [FPOS_W-1:0] rfpos_q;

	// shared pointer step and pointer compare, and the data compare
	logic             step_down;
	logic [CNT_W-1:0] ptr_step;
	logic [CNT_W-1:0] cmp_l, cmp_r;
	logic             ptr_eq;
	logic             data_eq;

	logic [CNT_W-1:0] req_pos;
	action_t          req_act;

	assign req_pos = CNT_W'(req_in.position);
	assign req_act = action_t'(req_in.action);

	assign step_down = (state_q == S_I_CHK) || (state_q == S_I_WR);
	assign ptr_step  = step_down ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
	assign cmp_l     = ((state_q == S_I_CHK) || (state_q == S_S_CHK)) ? ptr_q : ptr_step;
	assign cmp_r     = (state_q == S_I_CHK) ? pos_q : count_q;
	assign ptr_eq    = (cmp_l == cmp_r);
	assign data_eq   = (ram_rdata == val_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					case (req_act)
						ACT_VIEW:   state_d = (count_q == '0) ? S_RESP : S_V_RD;
						ACT_INSERT: begin
							if (req_pos > count_q || count_q == CNT_W'(CAPACITY)) begin
								state_d = S_RESP;
							end else begin
								state_d = S_I_CHK;
							end
						end
						ACT_DELETE: state_d = (req_pos >= count_q) ? S_RESP : S_D_CHK;
						ACT_SEARCH: state_d = S_S_CHK;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_V_RD:  state_d = S_V_OUT;
			S_V_OUT: begin
				if (res_take) begin
					state_d = ptr_eq ? S_IDLE : S_V_RD;
				end
			end
			S_I_CHK: state_d = ptr_eq ? S_RESP : S_I_WR;
			S_I_WR:  state_d = S_I_CHK;
			S_D_CHK: state_d = ptr_eq ? S_RESP : S_D_WR;
			S_D_WR:  state_d = S_D_CHK;
			S_S_CHK: state_d = ptr_eq ? S_RESP : S_S_CMP;
			S_S_CMP: state_d = data_eq ? S_RESP : S_S_CHK;
			S_RESP:  state_d = res_take ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle      = (state_q == S_IDLE);
		res_valid = (state_q == S_RESP) || (state_q == S_V_OUT);
		ram_we    = 1'b0;
		ram_waddr = ptr_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[ADDR_W-1:0];
		res.status         = rstat_q;
		res.found_position = rfpos_q;
		res.entry_value    = '0;
		res.entry_count    = count_q;
		res.last_of_run    = 1'b1;
		case (state_q)
			S_V_RD:  ram_re = 1'b1;
			S_V_OUT: begin
				res.status         = ST_OK;
				res.found_position = ptr_q[FPOS_W-1:0];
				res.entry_value    = ram_rdata;
				res.last_of_run    = ptr_eq;
			end
			S_I_CHK: begin
				if (ptr_eq) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[ADDR_W-1:0];
					ram_wdata = val_q;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_step[ADDR_W-1:0];
				end
			end
			S_D_CHK: begin
				ram_re    = !ptr_eq;
				ram_raddr = ptr_step[ADDR_W-1:0];
			end
			S_I_WR, S_D_WR: ram_we = 1'b1;
			S_S_CHK: ram_re = !ptr_eq;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_I_CHK && ptr_eq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == S_D_CHK && ptr_eq) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					pos_q   <= req_pos;
					val_q   <= req_in.data_value;
					rfpos_q <= '0;
					rstat_q <= ST_OK;
					case (req_act)
						ACT_INSERT: begin
							ptr_q <= count_q;
							if (req_pos > count_q) begin
								rstat_q <= ST_BOUNDS;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								rstat_q <= ST_FULL;
							end
						end
						ACT_DELETE: begin
							ptr_q <= req_pos;
							if (req_pos >= count_q) begin
								rstat_q <= ST_BOUNDS;
							end
						end
						default: ptr_q <= '0;
					endcase
				end
			end
			S_V_OUT: if (res_take) ptr_q <= ptr_step;
			S_I_WR, S_D_WR: ptr_q <= ptr_step;
			S_S_CHK: if (ptr_eq) rstat_q <= ST_NOTFOUND;
			S_S_CMP: begin
				if (data_eq) begin
					rfpos_q <= ptr_q[FPOS_W-1:0];
				end else begin
					ptr_q <= ptr_step;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/iaids_checker.sv
// Port-level checks for the indexed array block, bound to the top level.
// Depends on iaids_pkg and indexed_array_insert_delete_search.
`default_nettype none

module iaids_checker import iaids_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// after a request is taken the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one still open");

	// failures are single, closing responses with no value
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last_of_run && rsp.entry_value == '0)
		else $error("malformed failure response");

	// full only reported at capacity, count never above it
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= CNT_W'(CAPACITY)) &&
			(rsp.status != ST_FULL || rsp.entry_count == CNT_W'(CAPACITY)))
		else $error("entry count inconsistent");

endmodule

bind indexed_array_insert_delete_search iaids_checker u_chk (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for indexed_array_insert_delete_search: directed and random requests.
// Holds a mirror of the array and checks every response against it.
// Depends on iaids_pkg and the block's RTL only.

module tb_top import iaids_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD       = 10;
	localparam int RESET_CYCLES = 12;
	// longest single request is a full view
	localparam int SETTLE_CYCLES = 4 * CAPACITY + 20;
	// generous bound on the whole run
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;

	localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	// Mirror of the array: applies each accepted request, queues the
	// responses it must cause and checks them as they leave the block.
	class array_mirror;
		logic signed [DATA_W-1:0] words [CAPACITY];
		int unsigned held;
		rsp_t due_responses[$];
		int faults;

		function new();
			held   = 0;
			faults = 0;
		endfunction

		function int unsigned size();
			return held;
		endfunction

		function logic signed [DATA_W-1:0] word_at(int unsigned idx);
			return words[idx];
		endfunction

		function bit drained();
			return due_responses.size() == 0;
		endfunction

		function void queue_response(status_t st, int unsigned idx,
			logic signed [DATA_W-1:0] value, bit last);
			rsp_t r;
			r.status         = st;
			r.found_position = FPOS_W'(idx);
			r.entry_value    = value;
			r.entry_count    = CNT_W'(held);
			r.last_of_run    = last;
			due_responses.push_back(r);
		endfunction

		function void take_request(req_t r);
			int unsigned p;
			int unsigned k;
			bit hit;
			p   = r.position;
			hit = 1'b0;
			case (action_t'(r.action))
				ACT_VIEW: begin
					if (held == 0) begin
						queue_response(ST_OK, 0, '0, 1'b1);
					end else begin
						for (k = 0; k < held; k++)
							queue_response(ST_OK, k, words[k], k + 1 == held);
					end
				end
				ACT_INSERT: begin
					// index check takes priority over the full check
					if (p > held) begin
						queue_response(ST_BOUNDS, 0, '0, 1'b1);
					end else if (held >= CAPACITY) begin
						queue_response(ST_FULL, 0, '0, 1'b1);
					end else begin
						for (k = held; k > p; k--)
							words[k] = words[k-1];
						words[p] = r.data_value;
						held++;
						queue_response(ST_OK, 0, '0, 1'b1);
					end
				end
				ACT_DELETE: begin
					if (p >= held) begin
						queue_response(ST_BOUNDS, 0, '0, 1'b1);
					end else begin
						for (k = p; k + 1 < held; k++)
							words[k] = words[k+1];
						held--;
						queue_response(ST_OK, 0, '0, 1'b1);
					end
				end
				default: begin
					for (k = 0; k < held && !hit; k++) begin
						if (words[k] == r.data_value) begin
							queue_response(ST_OK, k, '0, 1'b1);
							hit = 1'b1;
						end
					end
					if (!hit)
						queue_response(ST_NOTFOUND, 0, '0, 1'b1);
				end
			endcase
		endfunction

		function void compare_field(string field, longint want, longint got);
			if (want != got) begin
				faults++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (due_responses.size() == 0) begin
				faults++;
				$display("%0t: response with none due: status %0d index %0d value %0d count %0d last %0d",
					$time, got.status, got.found_position, got.entry_value,
					got.entry_count, got.last_of_run);
				return;
			end
			want = due_responses.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found_position", want.found_position, got.found_position);
			compare_field("entry_value", longint'(want.entry_value),
				longint'(got.entry_value));
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	array_mirror sb = new();

	// idling levels, in percent, set per phase by the main sequence
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// long receiver hold-off: main asks, the receiver process counts it out
	int hold_ask      = 0;
	int hold_left     = 0;
	int cycles        = 0;

	indexed_array_insert_delete_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(PERIOD/2) clk = ~clk;

	// Watchdog: a hang or a lost response ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: stall driven on the falling edge, either random or a long hold-off.
	always @(negedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Responses are taken on the rising edge, with the values the block saw.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// Offer one request, with random idle cycles ahead of it; returns at the
	// edge where it was accepted, valid still high.
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.take_request(r);
	endtask

	task automatic issue(input action_t a, input int unsigned pos,
		input logic signed [DATA_W-1:0] value);
		req_t r;
		r.action     = a;
		r.position   = POS_W'(pos);
		r.data_value = value;
		send_request(r);
	endtask

	// Sender goes quiet until every due response has arrived.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (!sb.drained())
			@(posedge clk);
	endtask

	// Mostly in-range positions, and values often already stored, so
	// shifts, searches and views do real work; the rest is noise.
	function automatic req_t random_request();
		req_t r;
		int unsigned roll;
		int unsigned n;
		n    = sb.size();
		roll = $urandom_range(99);
		if (roll < 10)
			r.action = ACT_VIEW;
		else if (roll < 42)
			r.action = ACT_INSERT;
		else if (roll < 75)
			r.action = ACT_DELETE;
		else
			r.action = ACT_SEARCH;

		if ($urandom_range(99) < 15)
			r.position = POS_W'($urandom_range((1 << POS_W) - 1));
		else if (r.action == ACT_DELETE && n > 0)
			r.position = POS_W'($urandom_range(n - 1, 0));
		else
			r.position = POS_W'($urandom_range(n, 0));

		roll = $urandom_range(99);
		if (roll < 35 && n > 0)
			r.data_value = sb.word_at($urandom_range(n - 1, 0));
		else if (roll < 50)
			r.data_value = $urandom_range(7);    // small pool: duplicates
		else if (roll < 54)
			r.data_value = WORD_MIN;
		else if (roll < 58)
			r.data_value = WORD_MAX;
		else
			r.data_value = $urandom;
		return r;
	endfunction

	task automatic run_random(input int count, input bit with_hold);
		int i;
		for (i = 0; i < count; i++) begin
			// half-way, hold the receiver off while requests keep coming
			if (with_hold && i == count / 2)
				hold_ask = HOLD_CYCLES;
			send_request(random_request());
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty array first
		issue(ACT_VIEW, 0, '0);               // empty view gives one response
		issue(ACT_SEARCH, 0, '0);             // nothing to find
		issue(ACT_DELETE, 0, '0);             // delete on empty is out of range
		issue(ACT_INSERT, 1, 5);              // position past count
		// build [MIN, 0, MAX, -1, 0]
		issue(ACT_INSERT, 0, WORD_MAX);
		issue(ACT_INSERT, 0, WORD_MIN);
		issue(ACT_INSERT, 2, -1);             // append at count
		issue(ACT_INSERT, 1, 0);              // middle
		issue(ACT_INSERT, 4, 0);              // duplicate value
		issue(ACT_SEARCH, 0, 0);              // first of two matches
		issue(ACT_SEARCH, 0, -1);
		issue(ACT_SEARCH, 0, 5);              // no match
		issue(ACT_VIEW, 0, '0);
		issue(ACT_INSERT, (1 << POS_W) - 1, 1);
		issue(ACT_INSERT, 6, 1);              // count + 1
		issue(ACT_DELETE, 5, '0);             // position equal to count
		issue(ACT_DELETE, (1 << POS_W) - 1, '0);
		issue(ACT_DELETE, 4, '0);             // last entry
		issue(ACT_DELETE, 0, '0);             // first entry
		issue(ACT_DELETE, 1, '0);             // middle entry
		issue(ACT_SEARCH, (1 << POS_W) - 1, 32'sh5555_5555);  // position ignored
		issue(ACT_VIEW, (1 << POS_W) - 1, WORD_MIN);

		// Fill to capacity with random values at random legal positions
		while (sb.size() < CAPACITY)
			issue(ACT_INSERT, $urandom_range(sb.size(), 0), $urandom);
		issue(ACT_INSERT, CAPACITY, 9);        // full
		issue(ACT_INSERT, CAPACITY + 1, 9);    // bounds wins over full
		issue(ACT_INSERT, 0, 9);               // full
		issue(ACT_VIEW, 0, '0);                // longest run of responses
		issue(ACT_SEARCH, 0, sb.word_at(CAPACITY - 1));
		issue(ACT_DELETE, CAPACITY, '0);
		issue(ACT_DELETE, CAPACITY - 1, '0);

		// Random phases: free flowing, idle sender, stalling receiver, both
		run_random(60, 1'b0);
		wait_drained();
		send_idle_pct = 48;
		stall_pct     = 0;
		run_random(70, 1'b0);
		wait_drained();
		send_idle_pct = 0;
		stall_pct     = 48;
		run_random(70, 1'b1);
		wait_drained();
		send_idle_pct = 32;
		stall_pct     = 32;
		run_random(70, 1'b0);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.faults == 0 && sb.drained())
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
